@@ hw/rtl/rmmm_pkg.sv @@
`timescale 1ns / 1ps

package rmmm_pkg;

  localparam int unsigned SampleW    = 12;
  localparam int unsigned ModeValueW = 9;
  localparam int unsigned ModeCountW = 16;

endpackage

@@ hw/rtl/rmmm_ram.sv @@
`timescale 1ns / 1ps

module rmmm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 257,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rmmm_queue.sv @@
`timescale 1ns / 1ps

module rmmm_queue #(
  parameter int unsigned Width = 53
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned Depth = 2;
  localparam logic [1:0]  Full  = 2'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

@@ hw/rtl/rmmm_front.sv @@
`timescale 1ns / 1ps

module rmmm_front #(
  parameter int unsigned FracBits = 4,
  parameter int unsigned SeqWidth = 32,
  localparam int unsigned IdxW = rmmm_pkg::SampleW - FracBits + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rmmm_pkg::SampleW-1:0]  sample_i,
  input  logic                                 clr_busy_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output logic        [rmmm_pkg::SampleW-1:0]  q_sample_o,
  output logic        [IdxW-1:0]               q_idx_o,
  output logic        [SeqWidth-1:0]           q_seq_o
);

  import rmmm_pkg::*;

  localparam int unsigned Offset = 1 << (SampleW - 1 - FracBits);
  localparam int unsigned Half   = (1 << FracBits) >> 1;

  logic                neg;
  logic [SampleW-1:0]  mag;
  logic [SampleW:0]    sum;
  logic [SampleW:0]    rnd;
  logic [SeqWidth-1:0] seq_q, seq_d;

  // Round half away from zero: add one half to the magnitude, then restore the sign.
  always_comb begin
    neg = sample_i[SampleW-1];
    mag = neg ? SampleW'(-sample_i) : SampleW'(sample_i);
    sum = {1'b0, mag} + (SampleW + 1)'(Half);
    rnd = sum >> FracBits;
  end

  assign q_idx_o    = neg ? IdxW'(Offset) - IdxW'(rnd) : IdxW'(Offset) + IdxW'(rnd);
  assign in_ready_o = ~q_full_i & ~clr_busy_i;
  assign q_push_o   = in_valid_i & in_ready_o;
  assign q_sample_o = sample_i;
  assign q_seq_o    = seq_q;

  always_comb begin
    seq_d = seq_q;
    if (q_push_o && (seq_q != '1)) begin
      seq_d = seq_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else begin
      seq_q <= seq_d;
    end
  end

endmodule

@@ hw/rtl/rmmm_back.sv @@
`timescale 1ns / 1ps

module rmmm_back #(
  parameter int unsigned FracBits   = 4,
  parameter int unsigned CountWidth = 16,
  parameter int unsigned SeqWidth   = 32,
  localparam int unsigned IdxW = rmmm_pkg::SampleW - FracBits + 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  output logic                                   clr_busy_o,
  input  logic                                   q_valid_i,
  output logic                                   q_pop_o,
  input  logic        [rmmm_pkg::SampleW-1:0]    q_sample_i,
  input  logic        [IdxW-1:0]                 q_idx_i,
  input  logic        [SeqWidth-1:0]             q_seq_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [rmmm_pkg::SampleW-1:0]    hottest_o,
  output logic signed [rmmm_pkg::SampleW-1:0]    coldest_o,
  output logic signed [rmmm_pkg::ModeValueW-1:0] mode_value_o,
  output logic        [rmmm_pkg::ModeCountW-1:0] mode_count_o
);

  import rmmm_pkg::*;

  localparam int unsigned Offset  = 1 << (SampleW - 1 - FracBits);
  localparam int unsigned NumBins = 2 * Offset + 1;
  localparam int unsigned McW     = (CountWidth > ModeCountW) ? CountWidth : ModeCountW;
  localparam int unsigned MvW     = (IdxW > ModeValueW) ? IdxW : ModeValueW;
  localparam logic [IdxW-1:0] LastAddr = IdxW'(NumBins - 1);

  // Bin clearing after reset.
  logic            clr_busy_q, clr_busy_d;
  logic [IdxW-1:0] clr_addr_q, clr_addr_d;

  // Execute stage, holding the item whose histogram read is in flight.
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_byp_q, s1_byp_d;
  logic signed [SampleW-1:0] s1_sample_q;
  logic [IdxW-1:0]           s1_idx_q;
  logic [SeqWidth-1:0]       s1_seq_q;

  logic [CountWidth-1:0] wr_cnt_q;
  logic [SeqWidth-1:0]   wr_seen_q;

  logic                      any_seen_q;
  logic signed [SampleW-1:0] max_q, max_d;
  logic signed [SampleW-1:0] min_q, min_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  logic [CountWidth-1:0]     best_cnt_q, best_cnt_d;
  logic [SeqWidth-1:0]       best_seen_q, best_seen_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] hottest_q, coldest_q;
  logic [ModeValueW-1:0]     mode_value_q;
  logic [ModeCountW-1:0]     mode_count_q;

  logic                  fire, s1_free, pop;
  logic [CountWidth-1:0] cnt_rdata, cur_cnt, new_cnt, cnt_wdata;
  logic [SeqWidth-1:0]   seen_rdata, cur_seen, new_seen;
  logic [IdxW-1:0]       cnt_waddr;
  logic                  cnt_we, take;
  logic signed [IdxW-1:0] bin_s;
  logic signed [MvW-1:0]  bin_w;
  logic [McW-1:0]         cnt_w;

  rmmm_ram #(
    .Width(CountWidth),
    .Depth(NumBins)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (pop),
    .raddr_i(q_idx_i),
    .rdata_o(cnt_rdata)
  );

  rmmm_ram #(
    .Width(SeqWidth),
    .Depth(NumBins)
  ) u_seen_ram (
    .clk_i  (clk_i),
    .we_i   (fire),
    .waddr_i(s1_idx_q),
    .wdata_i(new_seen),
    .re_i   (pop),
    .raddr_i(q_idx_i),
    .rdata_o(seen_rdata)
  );

  assign fire    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign s1_free = ~s1_valid_q | fire;
  assign pop     = q_valid_i & s1_free & ~clr_busy_q;
  assign q_pop_o = pop;

  // A bin written in the same cycle that its next read was issued takes the written value.
  assign cur_cnt  = s1_byp_q ? wr_cnt_q : cnt_rdata;
  assign cur_seen = s1_byp_q ? wr_seen_q : seen_rdata;
  assign new_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
  assign new_seen = (cur_cnt == '0) ? s1_seq_q : cur_seen;

  assign cnt_we    = clr_busy_q | fire;
  assign cnt_waddr = clr_busy_q ? clr_addr_q : s1_idx_q;
  assign cnt_wdata = clr_busy_q ? '0 : new_cnt;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    s1_byp_d = pop ? (fire && (q_idx_i == s1_idx_q)) : s1_byp_q;
  end

  always_comb begin
    take = (new_cnt > best_cnt_q) ||
           ((new_cnt == best_cnt_q) && (s1_idx_q != best_idx_q) && (new_seen < best_seen_q));
    best_idx_d  = take ? s1_idx_q : best_idx_q;
    best_cnt_d  = (new_cnt > best_cnt_q) ? new_cnt : best_cnt_q;
    best_seen_d = take ? new_seen : best_seen_q;
    if (!any_seen_q) begin
      max_d = s1_sample_q;
      min_d = s1_sample_q;
    end else begin
      max_d = (s1_sample_q > max_q) ? s1_sample_q : max_q;
      min_d = (s1_sample_q < min_q) ? s1_sample_q : min_q;
    end
    bin_s = $signed(best_idx_d - IdxW'(Offset));
    bin_w = MvW'(bin_s);
    cnt_w = McW'(best_cnt_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      s1_byp_q    <= 1'b0;
      out_valid_q <= 1'b0;
      any_seen_q  <= 1'b0;
      max_q       <= '0;
      min_q       <= '0;
      best_idx_q  <= IdxW'(Offset);
      best_cnt_q  <= '0;
      best_seen_q <= '0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      s1_byp_q    <= s1_byp_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        any_seen_q  <= 1'b1;
        max_q       <= max_d;
        min_q       <= min_d;
        best_idx_q  <= best_idx_d;
        best_cnt_q  <= best_cnt_d;
        best_seen_q <= best_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_sample_q <= q_sample_i;
      s1_idx_q    <= q_idx_i;
      s1_seq_q    <= q_seq_i;
    end
    if (fire) begin
      wr_cnt_q     <= new_cnt;
      wr_seen_q    <= new_seen;
      hottest_q    <= max_d;
      coldest_q    <= min_d;
      mode_value_q <= bin_w[ModeValueW-1:0];
      mode_count_q <= cnt_w[ModeCountW-1:0];
    end
  end

  assign clr_busy_o   = clr_busy_q;
  assign out_valid_o  = out_valid_q;
  assign hottest_o    = hottest_q;
  assign coldest_o    = coldest_q;
  assign mode_value_o = $signed(mode_value_q);
  assign mode_count_o = mode_count_q;

endmodule

@@ hw/rtl/running_min_max_mode_core.sv @@
// Streaming temperature statistics: each sample beat (signed, FracBits fraction bits) yields one
// result beat with the largest and smallest sample so far and the mode of the samples rounded
// half away from zero to whole degrees, where a tie in count goes to the bin first seen earliest
// and counts saturate. A front stage rounds and numbers each sample and hands it through a
// two-entry queue to a back stage that does the histogram read-modify-write, so one beat is
// accepted every clock cycle while the result output is not stalled; a sample passes through
// the queue, then the registered read of the bin-count memory, then the result register. After
// reset the back stage clears the 2^(12-FracBits)+1 bin counters (257 by default), one per
// cycle, and in_ready_o stays low until that pass is done.
`timescale 1ns / 1ps

module running_min_max_mode_core #(
  parameter int unsigned FracBits   = 4,
  parameter int unsigned CountWidth = 16,
  parameter int unsigned SeqWidth   = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rmmm_pkg::SampleW-1:0]    sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [rmmm_pkg::SampleW-1:0]    hottest_o,
  output logic signed [rmmm_pkg::SampleW-1:0]    coldest_o,
  output logic signed [rmmm_pkg::ModeValueW-1:0] mode_value_o,
  output logic        [rmmm_pkg::ModeCountW-1:0] mode_count_o
);

  import rmmm_pkg::*;

  localparam int unsigned IdxW = SampleW - FracBits + 1;
  localparam int unsigned QW   = SampleW + IdxW + SeqWidth;

  logic                clr_busy, q_full, q_push, q_pop, q_valid;
  logic [SampleW-1:0]  f_sample;
  logic [IdxW-1:0]     f_idx;
  logic [SeqWidth-1:0] f_seq;
  logic [QW-1:0]       q_wdata, q_rdata;

  rmmm_front #(
    .FracBits(FracBits),
    .SeqWidth(SeqWidth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .clr_busy_i(clr_busy),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_sample_o(f_sample),
    .q_idx_o   (f_idx),
    .q_seq_o   (f_seq)
  );

  assign q_wdata = {f_sample, f_idx, f_seq};

  rmmm_queue #(
    .Width(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  rmmm_back #(
    .FracBits  (FracBits),
    .CountWidth(CountWidth),
    .SeqWidth  (SeqWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_busy_o  (clr_busy),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_sample_i  (q_rdata[QW-1 -: SampleW]),
    .q_idx_i     (q_rdata[SeqWidth +: IdxW]),
    .q_seq_i     (q_rdata[SeqWidth-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hottest_o   (hottest_o),
    .coldest_o   (coldest_o),
    .mode_value_o(mode_value_o),
    .mode_count_o(mode_count_o)
  );

endmodule

@@ hw/rtl/rmmm_checker.sv @@
`timescale 1ns / 1ps

module rmmm_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [rmmm_pkg::SampleW-1:0]    hottest_o,
  input logic signed [rmmm_pkg::SampleW-1:0]    coldest_o,
  input logic signed [rmmm_pkg::ModeValueW-1:0] mode_value_o,
  input logic        [rmmm_pkg::ModeCountW-1:0] mode_count_o
);

  logic took_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      took_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      took_q <= 1'b1;
    end
  end

  // A result beat never shows up before a sample beat has been taken.
  a_no_result_before_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> took_q)
    else $error("result beat before any sample beat");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hottest_o >= coldest_o))
    else $error("hottest below coldest");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hottest_o) && $stable(coldest_o) &&
      $stable(mode_value_o) && $stable(mode_count_o))
    else $error("result payload changed while stalled");

endmodule

bind running_min_max_mode_core rmmm_checker u_rmmm_checker (.*);

@@ dv/tb_running_min_max_mode_core.sv @@
`timescale 1ns / 1ps

module tb_running_min_max_mode_core;
  import rmmm_pkg::*;

  localparam int FRAC_W = 4;
  localparam int COUNT_W = 16;
  localparam int SEQ_W = 32;
  localparam int BIN_OFFSET = 1 << (SampleW - 1 - FRAC_W);
  localparam int NUM_BINS = 2 * BIN_OFFSET + 1;
  localparam int HALF_LSB = (1 << FRAC_W) >> 1;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;
  localparam longint unsigned SEQ_MAX = (64'd1 << SEQ_W) - 1;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [SampleW-1:0]    hottest;
    logic signed [SampleW-1:0]    coldest;
    logic signed [ModeValueW-1:0] mode_value;
    logic        [ModeCountW-1:0] mode_count;
  } temp_stats_t;

  class temp_stats_scoreboard;
    bit                        seen_any;
    logic signed [SampleW-1:0] hottest_so_far;
    logic signed [SampleW-1:0] coldest_so_far;
    longint unsigned           bin_hits [NUM_BINS];
    longint unsigned           bin_first_seq [NUM_BINS];
    longint unsigned           sample_seq;
    int                        lead_bin;
    longint unsigned           lead_count;
    temp_stats_t               expected_stats [$];
    int                        failures;

    function new();
      seen_any = 1'b0;
      hottest_so_far = '0;
      coldest_so_far = '0;
      foreach (bin_hits[i]) begin
        bin_hits[i] = 0;
        bin_first_seq[i] = 0;
      end
      sample_seq = 0;
      lead_bin = 0;
      lead_count = 0;
      failures = 0;
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void take_sample(logic signed [SampleW-1:0] s);
      int              value;
      int              mag;
      int              bin;
      int              idx;
      longint unsigned seq;
      longint unsigned hits;
      temp_stats_t     e;
      value = s;
      mag = (value < 0) ? -value : value;
      bin = (mag + HALF_LSB) >>> FRAC_W;
      if (value < 0) begin
        bin = -bin;
      end
      idx = bin + BIN_OFFSET;
      seq = sample_seq;
      if (sample_seq < SEQ_MAX) begin
        sample_seq++;
      end
      if (!seen_any) begin
        hottest_so_far = s;
        coldest_so_far = s;
        seen_any = 1'b1;
      end else begin
        if (s > hottest_so_far) hottest_so_far = s;
        if (s < coldest_so_far) coldest_so_far = s;
      end
      hits = bin_hits[idx];
      if (hits == 0) begin
        bin_first_seq[idx] = seq;
      end
      if (hits < COUNT_MAX) begin
        hits++;
      end
      bin_hits[idx] = hits;
      if (hits > lead_count) begin
        lead_bin = bin;
        lead_count = hits;
      end else if (hits == lead_count && bin != lead_bin) begin
        if (bin_first_seq[idx] < bin_first_seq[lead_bin + BIN_OFFSET]) begin
          lead_bin = bin;
        end
      end
      e.hottest = hottest_so_far;
      e.coldest = coldest_so_far;
      e.mode_value = ModeValueW'(lead_bin);
      e.mode_count = ModeCountW'(lead_count);
      expected_stats = {expected_stats, e};
    endfunction

    function void check_stats(temp_stats_t got);
      temp_stats_t e;
      if (expected_stats.size() == 0) begin
        note_failure($sformatf("result beat with nothing expected: hot %0d cold %0d mode %0d x%0d",
                               got.hottest, got.coldest, got.mode_value, got.mode_count));
        return;
      end
      e = expected_stats.pop_front();
      if (got.hottest !== e.hottest || got.coldest !== e.coldest ||
          got.mode_value !== e.mode_value || got.mode_count !== e.mode_count) begin
        note_failure($sformatf({"mismatch: expected hot %0d cold %0d mode %0d x%0d, ",
                                "got hot %0d cold %0d mode %0d x%0d"},
                               e.hottest, e.coldest, e.mode_value, e.mode_count,
                               got.hottest, got.coldest, got.mode_value, got.mode_count));
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic signed [SampleW-1:0]      sample_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic signed [SampleW-1:0]      hottest_o;
  logic signed [SampleW-1:0]      coldest_o;
  logic signed [ModeValueW-1:0]   mode_value_o;
  logic        [ModeCountW-1:0]   mode_count_o;

  bit                             no_idle = 1'b0;
  temp_stats_scoreboard           sb = new();

  running_min_max_mode_core #(
    .FracBits  (FRAC_W),
    .CountWidth(COUNT_W),
    .SeqWidth  (SEQ_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hottest_o   (hottest_o),
    .coldest_o   (coldest_o),
    .mode_value_o(mode_value_o),
    .mode_count_o(mode_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_sample(input logic signed [SampleW-1:0] s);
    in_valid_i <= 1'b1;
    sample_i <= s;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.take_sample(s);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [SampleW-1:0] near_bin(int bin);
    int v;
    v = bin * (1 << FRAC_W) + int'($urandom_range(0, 1 << FRAC_W)) - HALF_LSB;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return SampleW'(v);
  endfunction

  function automatic logic signed [SampleW-1:0] any_sample();
    return SampleW'($urandom_range(0, 4095));
  endfunction

  always begin
    int stall_left;
    temp_stats_t got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.hottest = hottest_o;
        got.coldest = coldest_o;
        got.mode_value = mode_value_o;
        got.mode_count = mode_count_o;
        sb.check_stats(got);
      end
      if (no_idle) begin
        stall_left = 0;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int directed_samples [$];
    int focus [3];
    directed_samples = '{5, 32, 48, 48, 32, 0, 2047, -2048, 8, -8, 7, -7, 24, -24,
                         23, -25, 1, -1, 40, -40, 1365, -1366, 2040, -2040, 48};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_samples[i]) begin
      send_sample(SampleW'(directed_samples[i]));
    end

    repeat (300) begin
      send_sample(any_sample());
    end

    foreach (focus[i]) begin
      focus[i] = int'($urandom_range(0, NUM_BINS - 1)) - BIN_OFFSET;
    end
    repeat (880) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(any_sample());
      end else begin
        send_sample(near_bin(focus[$urandom_range(0, 2)]));
      end
    end

    no_idle = 1'b1;
    repeat (50) begin
      send_sample(near_bin(focus[$urandom_range(0, 2)]));
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
